FILE: hw/rtl/ecal_pkg.sv
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared types, queue sizes and fixed-point reciprocals for the epoch-seconds
// to calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ecal_pkg;

  localparam int MID_DEPTH = 8;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int MID_CW    = $clog2(MID_DEPTH + 1);
  localparam logic [MID_CW-1:0] MID_FULL = MID_CW'(MID_DEPTH);

  localparam int OUT_DEPTH = 16;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);
  localparam logic [OUT_CW-1:0] OUT_FULL = OUT_CW'(OUT_DEPTH);

  // seconds / 128 is biased by 675 * 2^23 so the day quotient stays positive
  localparam logic [33:0] DAY_BIAS  = 34'(64'd675 << 23);
  localparam logic [24:0] DAY_RECIP = 25'((64'd1 << 34) / 64'd675);
  localparam logic [11:0] DAY_DIV   = 12'd675;

  // day bias plus shift to March plus 64 eras
  localparam logic [24:0] ZZ_BIAS = 25'(719468 + 64 * 146097 - 8388608);

  localparam logic [13:0] ERA_RECIP    = 14'((64'd1 << 31) / 64'd146097);
  localparam logic [23:0] DAYS_PER_ERA = 24'd146097;
  localparam logic [17:0] HOUR_RECIP   = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MIN_RECIP    = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [18:0] QUAD_RECIP   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] YEAR_RECIP   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [11:0] MP_RECIP     = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  // 64 eras of 400 years plus 1900
  localparam logic [17:0] YEAR_OFFSET = 18'd27500;

  typedef struct packed {
    logic [23:0] zz;
    logic [16:0] sod;
  } ecal_split_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [15:0] years_since_1900;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
  } ecal_result_t;

  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ecal_front.sv
// ----------------------------------------------------------------------------
// ecal_front
// Input stage: splits epoch seconds into a biased day count and the second
// of the day, with credit flow control toward the middle queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic signed [39:0]        in_epoch_seconds,
  output logic                      in_full,
  input  logic                      mid_pop,
  output logic                      mid_push,
  output ecal_pkg::ecal_split_t     mid_data
);

  logic [ecal_pkg::MID_CW-1:0] occ_r, occ_nxt;
  logic        acc;
  logic [2:0]  vld_r;

  logic [33:0] u0_r, u1_r;
  logic [6:0]  r70_r, r71_r, r72_r;
  logic [24:0] qe1_r, qe2_r;
  logic [11:0] rem2_r;

  logic [48:0] p_day;
  logic [33:0] qmul;
  logic [33:0] diff;
  logic [1:0]  k;
  logic [11:0] r2w;
  logic [24:0] q_sum;

  assign acc     = in_push & ~in_full;
  assign in_full = (occ_r == ecal_pkg::MID_FULL);

  always_comb begin
    occ_nxt = occ_r;
    case ({acc, mid_pop})
      2'b10:   occ_nxt = occ_r + 1'b1;
      2'b01:   occ_nxt = occ_r - 1'b1;
      default: occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      vld_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      vld_r <= {vld_r[1:0], acc};
    end
  end

  assign p_day = u0_r[33:10] * ecal_pkg::DAY_RECIP;
  assign qmul  = 34'(qe1_r) * 34'(ecal_pkg::DAY_DIV);
  assign diff  = u1_r - qmul;

  always_ff @(posedge clk) begin
    u0_r   <= {in_epoch_seconds[39], in_epoch_seconds[39:7]} + ecal_pkg::DAY_BIAS;
    r70_r  <= in_epoch_seconds[6:0];
    qe1_r  <= p_day[48:24];
    u1_r   <= u0_r;
    r71_r  <= r70_r;
    rem2_r <= diff[11:0];
    qe2_r  <= qe1_r;
    r72_r  <= r71_r;
  end

  always_comb begin
    if (rem2_r >= 12'd2025) begin
      k = 2'd3;
    end else if (rem2_r >= 12'd1350) begin
      k = 2'd2;
    end else if (rem2_r >= 12'd675) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
    r2w   = rem2_r - 12'(k) * ecal_pkg::DAY_DIV;
    q_sum = qe2_r + 25'(k) + ecal_pkg::ZZ_BIAS;
  end

  assign mid_push     = vld_r[2];
  assign mid_data.zz  = q_sum[23:0];
  assign mid_data.sod = {r2w[9:0], r72_r};

endmodule

`default_nettype wire

FILE: hw/rtl/ecal_mid_queue.sv
// ----------------------------------------------------------------------------
// ecal_mid_queue
// Short queue of split day / second-of-day beats between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_mid_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ecal_pkg::ecal_split_t wdata,
  input  logic                  pop,
  output logic                  empty,
  output ecal_pkg::ecal_split_t rdata
);

  ecal_pkg::ecal_split_t mem_r [ecal_pkg::MID_DEPTH];
  logic [ecal_pkg::MID_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [ecal_pkg::MID_CW-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ecal_back.sv
// ----------------------------------------------------------------------------
// ecal_back
// Eight-stage pipeline: era split, year of era, day of year, month and day,
// plus the hour / minute / second lane and the weekday.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   mid_empty,
  input  ecal_pkg::ecal_split_t  mid_data,
  output logic                   mid_pop,
  input  logic                   out_taken,
  output logic                   res_push,
  output ecal_pkg::ecal_result_t res_data
);

  logic [ecal_pkg::OUT_CW-1:0] occ_r, occ_nxt;
  logic [8:1] vld_r;
  logic       issue;

  // stage 1
  logic [23:0] b1_zz_r;
  logic [16:0] b1_sod_r;
  // stage 2
  logic [23:0] b2_zz_r;
  logic [16:0] b2_sod_r;
  logic [6:0]  b2_era_r;
  logic [4:0]  b2_hour_r;
  logic [2:0]  b2_wd_r;
  // stage 3
  logic [18:0] b3_doe_r;
  logic [11:0] b3_soh_r;
  logic [6:0]  b3_era_r;
  logic [4:0]  b3_hour_r;
  logic [2:0]  b3_wd_r;
  // stage 4
  logic [17:0] b4_doe_r;
  logic [11:0] b4_soh_r;
  logic [6:0]  b4_era_r;
  logic [4:0]  b4_hour_r;
  logic [5:0]  b4_min_r;
  logic [2:0]  b4_wd_r;
  // stage 5
  logic [17:0] b5_n_r;
  logic [17:0] b5_doe_r;
  logic [6:0]  b5_era_r;
  logic [4:0]  b5_hour_r;
  logic [5:0]  b5_min_r;
  logic [5:0]  b5_sec_r;
  logic [2:0]  b5_wd_r;
  // stage 6
  logic [8:0]  b6_yoe_r;
  logic [17:0] b6_doe_r;
  logic [6:0]  b6_era_r;
  logic [4:0]  b6_hour_r;
  logic [5:0]  b6_min_r;
  logic [5:0]  b6_sec_r;
  logic [2:0]  b6_wd_r;
  // stage 7
  logic [8:0]  b7_doy_r;
  logic        b7_leap_r;
  logic [8:0]  b7_yoe_r;
  logic [6:0]  b7_era_r;
  logic [4:0]  b7_hour_r;
  logic [5:0]  b7_min_r;
  logic [5:0]  b7_sec_r;
  logic [2:0]  b7_wd_r;
  // stage 8
  logic [3:0]  b8_mp_r;
  logic [8:0]  b8_doy_r;
  logic        b8_leap_r;
  logic [8:0]  b8_yoe_r;
  logic [6:0]  b8_era_r;
  logic [4:0]  b8_hour_r;
  logic [5:0]  b8_min_r;
  logic [5:0]  b8_sec_r;
  logic [2:0]  b8_wd_r;

  logic [37:0] p_era;
  logic [34:0] p_hour;
  logic [23:0] wd_x;
  logic [5:0]  wd_s1;
  logic [3:0]  wd_s2;
  logic [2:0]  wd_nxt;
  logic [23:0] doe_diff;
  logic [16:0] soh_diff;
  logic        era_corr;
  logic [18:0] doe_fix;
  logic [24:0] p_min;
  logic [36:0] p_quad;
  logic [2:0]  cent4;
  logic        last_day;
  logic [17:0] n_nxt;
  logic [11:0] sec_diff;
  logic [36:0] p_year;
  logic [1:0]  cent;
  logic [17:0] yr_base;
  logic [17:0] doy_diff;
  logic        leap_nxt;
  logic [10:0] mp_x;
  logic [22:0] p_mp;
  logic [8:0]  mstart;
  logic [8:0]  dom_w;
  logic        late;
  logic [17:0] yrs_w;

  assign issue   = ~mid_empty & (occ_r != ecal_pkg::OUT_FULL);
  assign mid_pop = issue;

  always_comb begin
    occ_nxt = occ_r;
    case ({issue, out_taken})
      2'b10:   occ_nxt = occ_r + 1'b1;
      2'b01:   occ_nxt = occ_r - 1'b1;
      default: occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      vld_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      vld_r <= {vld_r[7:1], issue};
    end
  end

  // stage 1 -> 2
  always_comb begin
    p_era  = b1_zz_r * ecal_pkg::ERA_RECIP;
    p_hour = b1_sod_r * ecal_pkg::HOUR_RECIP;
    wd_x   = b1_zz_r + 24'd3;
    wd_s1  = '0;
    for (int i = 0; i < 8; i++) begin
      wd_s1 = wd_s1 + 6'(wd_x[3*i +: 3]);
    end
    wd_s2  = {1'b0, wd_s1[5:3]} + {1'b0, wd_s1[2:0]};
    wd_nxt = (wd_s2 >= 4'd7) ? 3'(wd_s2 - 4'd7) : wd_s2[2:0];
  end

  // stage 2 -> 3
  assign doe_diff = b2_zz_r - 24'(b2_era_r) * ecal_pkg::DAYS_PER_ERA;
  assign soh_diff = b2_sod_r - 17'(b2_hour_r) * 17'd3600;

  // stage 3 -> 4
  assign era_corr = (b3_doe_r >= 19'(ecal_pkg::DAYS_PER_ERA));
  assign doe_fix  = era_corr ? (b3_doe_r - 19'(ecal_pkg::DAYS_PER_ERA)) : b3_doe_r;
  assign p_min    = b3_soh_r * ecal_pkg::MIN_RECIP;

  // stage 4 -> 5
  always_comb begin
    p_quad   = b4_doe_r * ecal_pkg::QUAD_RECIP;
    cent4    = 3'(b4_doe_r >= 18'd36524) + 3'(b4_doe_r >= 18'd73048)
             + 3'(b4_doe_r >= 18'd109572) + 3'(b4_doe_r >= 18'd146096);
    last_day = (b4_doe_r == 18'd146096);
    n_nxt    = b4_doe_r - 18'(p_quad[36:29]) + 18'(cent4) - 18'(last_day);
    sec_diff = b4_soh_r - 12'(b4_min_r) * 12'd60;
  end

  // stage 5 -> 6
  assign p_year = b5_n_r * ecal_pkg::YEAR_RECIP;

  // stage 6 -> 7
  always_comb begin
    cent     = 2'(b6_yoe_r >= 9'd100) + 2'(b6_yoe_r >= 9'd200) + 2'(b6_yoe_r >= 9'd300);
    yr_base  = 18'(b6_yoe_r) * 18'd365 + 18'(b6_yoe_r[8:2]) - 18'(cent);
    doy_diff = b6_doe_r - yr_base;
    leap_nxt = (b6_yoe_r[1:0] == 2'b00) &&
               !((b6_yoe_r == 9'd100) || (b6_yoe_r == 9'd200) || (b6_yoe_r == 9'd300));
  end

  // stage 7 -> 8
  assign mp_x = 11'(b7_doy_r) * 11'd5 + 11'd2;
  assign p_mp = mp_x * ecal_pkg::MP_RECIP;

  always_ff @(posedge clk) begin
    b1_zz_r   <= mid_data.zz;
    b1_sod_r  <= mid_data.sod;

    b2_zz_r   <= b1_zz_r;
    b2_sod_r  <= b1_sod_r;
    b2_era_r  <= p_era[37:31];
    b2_hour_r <= p_hour[33:29];
    b2_wd_r   <= wd_nxt;

    b3_doe_r  <= doe_diff[18:0];
    b3_soh_r  <= soh_diff[11:0];
    b3_era_r  <= b2_era_r;
    b3_hour_r <= b2_hour_r;
    b3_wd_r   <= b2_wd_r;

    b4_doe_r  <= doe_fix[17:0];
    b4_soh_r  <= b3_soh_r;
    b4_era_r  <= b3_era_r + 7'(era_corr);
    b4_hour_r <= b3_hour_r;
    b4_min_r  <= p_min[23:18];
    b4_wd_r   <= b3_wd_r;

    b5_n_r    <= n_nxt;
    b5_doe_r  <= b4_doe_r;
    b5_era_r  <= b4_era_r;
    b5_hour_r <= b4_hour_r;
    b5_min_r  <= b4_min_r;
    b5_sec_r  <= sec_diff[5:0];
    b5_wd_r   <= b4_wd_r;

    b6_yoe_r  <= p_year[35:27];
    b6_doe_r  <= b5_doe_r;
    b6_era_r  <= b5_era_r;
    b6_hour_r <= b5_hour_r;
    b6_min_r  <= b5_min_r;
    b6_sec_r  <= b5_sec_r;
    b6_wd_r   <= b5_wd_r;

    b7_doy_r  <= doy_diff[8:0];
    b7_leap_r <= leap_nxt;
    b7_yoe_r  <= b6_yoe_r;
    b7_era_r  <= b6_era_r;
    b7_hour_r <= b6_hour_r;
    b7_min_r  <= b6_min_r;
    b7_sec_r  <= b6_sec_r;
    b7_wd_r   <= b6_wd_r;

    b8_mp_r   <= p_mp[22:19];
    b8_doy_r  <= b7_doy_r;
    b8_leap_r <= b7_leap_r;
    b8_yoe_r  <= b7_yoe_r;
    b8_era_r  <= b7_era_r;
    b8_hour_r <= b7_hour_r;
    b8_min_r  <= b7_min_r;
    b8_sec_r  <= b7_sec_r;
    b8_wd_r   <= b7_wd_r;
  end

  // final assembly
  always_comb begin
    mstart = ecal_pkg::month_start(b8_mp_r);
    dom_w  = b8_doy_r - mstart + 9'd1;
    late   = (b8_mp_r >= 4'd10);
    yrs_w  = 18'(b8_era_r) * 18'd400 + 18'(b8_yoe_r) + 18'(late) - ecal_pkg::YEAR_OFFSET;

    res_data.second           = b8_sec_r;
    res_data.minute           = b8_min_r;
    res_data.hour             = b8_hour_r;
    res_data.day_of_month     = dom_w[4:0];
    res_data.month_index      = late ? (b8_mp_r - 4'd10) : (b8_mp_r + 4'd2);
    res_data.years_since_1900 = yrs_w[15:0];
    res_data.weekday          = b8_wd_r;
    res_data.day_of_year      = late ? (b8_doy_r - 9'd306)
                                     : (b8_doy_r + 9'd59 + 9'(b8_leap_r));
  end

  assign res_push = vld_r[8];

endmodule

`default_nettype wire

FILE: hw/rtl/ecal_out_queue.sv
// ----------------------------------------------------------------------------
// ecal_out_queue
// Result queue; the head entry drives the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ecal_pkg::ecal_result_t wdata,
  input  logic                   pop,
  output logic                   empty,
  output ecal_pkg::ecal_result_t rdata
);

  ecal_pkg::ecal_result_t mem_r [ecal_pkg::OUT_DEPTH];
  logic [ecal_pkg::OUT_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [ecal_pkg::OUT_CW-1:0] cnt_r;
  logic take;

  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];
  assign take  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (take) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, take})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/epoch_seconds_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Signed epoch seconds in, broken-down UTC calendar time out.
//
// Input side is a queue port: a beat is taken on a clock edge with in_push
// high and in_full low. Result side is a queue port too: the oldest result
// sits on the out_ ports while out_empty is low and leaves on an edge with
// out_pop high.
// One beat per cycle sustained while out_pop keeps the result queue from
// filling. The front does the split by 86400, the back era, year, month
// and day through its multiplier stages.
// The front holds up to 8 beats in flight and queued; the back holds up to
// 16 beats in flight and in the result queue. When out_pop stays low the
// result queue fills, the back stops drawing, and in_full rises once the
// front runs out of credit; nothing is dropped.
// Synchronous reset empties both queues and the pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic signed [39:0] in_epoch_seconds,
  output logic               in_full,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [5:0]         out_second,
  output logic [5:0]         out_minute,
  output logic [4:0]         out_hour,
  output logic [4:0]         out_day_of_month,
  output logic [3:0]         out_month_index,
  output logic signed [15:0] out_years_since_1900,
  output logic [2:0]         out_weekday,
  output logic [8:0]         out_day_of_year
);

  logic                   mid_push;
  logic                   mid_pop;
  logic                   mid_empty;
  ecal_pkg::ecal_split_t  mid_wdata;
  ecal_pkg::ecal_split_t  mid_rdata;
  logic                   res_push;
  ecal_pkg::ecal_result_t res_wdata;
  ecal_pkg::ecal_result_t res_rdata;
  logic                   out_taken;

  assign out_taken = out_pop & ~out_empty;

  ecal_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_epoch_seconds (in_epoch_seconds),
    .in_full          (in_full),
    .mid_pop          (mid_pop),
    .mid_push         (mid_push),
    .mid_data         (mid_wdata)
  );

  ecal_mid_queue u_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_rdata)
  );

  ecal_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_taken (out_taken),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  ecal_out_queue u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (res_rdata)
  );

  assign out_second           = res_rdata.second;
  assign out_minute           = res_rdata.minute;
  assign out_hour             = res_rdata.hour;
  assign out_day_of_month     = res_rdata.day_of_month;
  assign out_month_index      = res_rdata.month_index;
  assign out_years_since_1900 = $signed(res_rdata.years_since_1900);
  assign out_weekday          = res_rdata.weekday;
  assign out_day_of_year      = res_rdata.day_of_year;

endmodule

`default_nettype wire
